FILE: sv/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and codes for the line pixel stepper: item layouts, step
// sign codes and the coordinate width.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

  localparam int COORD_BITS = 10;
  localparam int COLOR_BITS = 16;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS:0]   err_t;
  typedef logic [COORD_BITS:0]   count_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic [1:0]            sign_t;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // two-bit two's complement step per axis
  localparam sign_t SIGN_ZERO = 2'b00;
  localparam sign_t SIGN_POS  = 2'b01;
  localparam sign_t SIGN_NEG  = 2'b11;

  typedef struct packed {
    logic   cmd;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t pen_color;
  } lps_in_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_pixel;
  } lps_out_t;

  // result of one processed item
  typedef struct packed {
    logic     valid;
    lps_out_t pixel;
  } lps_res_t;

endpackage

`default_nettype wire

FILE: sv/lps_in_reg.sv
// ----------------------------------------------------------------------------
// lps_in_reg
// Input register stage: holds one accepted item until the stepper takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_in_reg
  import lps_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    step_valid,
  output logic         step_ready,
  input  wire lps_in_t step_data,
  input  wire logic    advance,
  output logic         held_valid,
  output lps_in_t      held_item
);

  assign step_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (step_ready) begin
      held_valid <= step_valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (step_valid && step_ready) begin
      held_item <= step_data;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lps_core.sv
// ----------------------------------------------------------------------------
// lps_core
// Line state and single-pass stepping logic: loads a line on start, emits
// the current pixel and advances the point on each step.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_core
  import lps_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    fire,
  input  wire lps_in_t item,
  output lps_res_t     result
);

  coord_t cur_x, cur_y;
  err_t   err_x, err_y;
  coord_t abs_dx, abs_dy;
  coord_t major_len;
  sign_t  step_sign_x, step_sign_y;
  count_t pixel_count;
  color_t held_color;
  logic   line_active;

  coord_t cur_x_next, cur_y_next;
  err_t   err_x_next, err_y_next;
  coord_t abs_dx_next, abs_dy_next;
  coord_t major_len_next;
  sign_t  step_sign_x_next, step_sign_y_next;
  count_t pixel_count_next;
  color_t held_color_next;
  logic   line_active_next;

  // start decode
  coord_t new_dx, new_dy, new_major;
  sign_t  new_sx, new_sy;

  // step arithmetic
  err_t   sum_x, sum_y;
  logic   is_last;

  always_comb begin
    if (item.end_x > item.start_x) begin
      new_dx = item.end_x - item.start_x;
      new_sx = SIGN_POS;
    end else if (item.end_x == item.start_x) begin
      new_dx = '0;
      new_sx = SIGN_ZERO;
    end else begin
      new_dx = item.start_x - item.end_x;
      new_sx = SIGN_NEG;
    end
    if (item.end_y > item.start_y) begin
      new_dy = item.end_y - item.start_y;
      new_sy = SIGN_POS;
    end else if (item.end_y == item.start_y) begin
      new_dy = '0;
      new_sy = SIGN_ZERO;
    end else begin
      new_dy = item.start_y - item.end_y;
      new_sy = SIGN_NEG;
    end
    new_major = (new_dx > new_dy) ? new_dx : new_dy;
  end

  assign is_last = (pixel_count == {1'b0, major_len});
  assign sum_x   = err_x + {1'b0, abs_dx};
  assign sum_y   = err_y + {1'b0, abs_dy};

  always_comb begin
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    err_x_next       = err_x;
    err_y_next       = err_y;
    abs_dx_next      = abs_dx;
    abs_dy_next      = abs_dy;
    major_len_next   = major_len;
    step_sign_x_next = step_sign_x;
    step_sign_y_next = step_sign_y;
    pixel_count_next = pixel_count;
    held_color_next  = held_color;
    line_active_next = line_active;
    result           = '0;

    if (fire && item.cmd == CMD_START) begin
      // first pixel is the start point; the first advance can never move
      // an axis since each delta is at most the major length
      result.valid             = 1'b1;
      result.pixel.pixel_x     = item.start_x;
      result.pixel.pixel_y     = item.start_y;
      result.pixel.pixel_color = item.pen_color;
      result.pixel.last_pixel  = (new_major == '0);

      cur_x_next       = item.start_x;
      cur_y_next       = item.start_y;
      abs_dx_next      = new_dx;
      abs_dy_next      = new_dy;
      major_len_next   = new_major;
      step_sign_x_next = new_sx;
      step_sign_y_next = new_sy;
      held_color_next  = item.pen_color;
      err_x_next       = {1'b0, new_dx};
      err_y_next       = {1'b0, new_dy};
      pixel_count_next = (new_major == '0) ? count_t'(0) : count_t'(1);
      line_active_next = (new_major != '0);
    end else if (fire && line_active) begin
      result.valid             = 1'b1;
      result.pixel.pixel_x     = cur_x;
      result.pixel.pixel_y     = cur_y;
      result.pixel.pixel_color = held_color;
      result.pixel.last_pixel  = is_last;

      if (is_last) begin
        line_active_next = 1'b0;
      end else begin
        pixel_count_next = pixel_count + count_t'(1);
        if (sum_x > {1'b0, major_len}) begin
          err_x_next = sum_x - {1'b0, major_len};
          cur_x_next = cur_x + {{(COORD_BITS-2){step_sign_x[1]}}, step_sign_x};
        end else begin
          err_x_next = sum_x;
        end
        if (sum_y > {1'b0, major_len}) begin
          err_y_next = sum_y - {1'b0, major_len};
          cur_y_next = cur_y + {{(COORD_BITS-2){step_sign_y[1]}}, step_sign_y};
        end else begin
          err_y_next = sum_y;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      err_x       <= '0;
      err_y       <= '0;
      abs_dx      <= '0;
      abs_dy      <= '0;
      major_len   <= '0;
      step_sign_x <= SIGN_ZERO;
      step_sign_y <= SIGN_ZERO;
      pixel_count <= '0;
      held_color  <= '0;
      line_active <= 1'b0;
    end else begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      err_x       <= err_x_next;
      err_y       <= err_y_next;
      abs_dx      <= abs_dx_next;
      abs_dy      <= abs_dy_next;
      major_len   <= major_len_next;
      step_sign_x <= step_sign_x_next;
      step_sign_y <= step_sign_y_next;
      pixel_count <= pixel_count_next;
      held_color  <= held_color_next;
      line_active <= line_active_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    line_active |-> pixel_count <= {1'b0, major_len})
    else $error("pixel count ran past the major length");

  a_err_bound: assert property (@(posedge clk) disable iff (rst)
    (err_x <= {major_len, 1'b0}) && (err_y <= {major_len, 1'b0}))
    else $error("error accumulator above twice the major length");

  a_major_covers: assert property (@(posedge clk) disable iff (rst)
    (major_len >= abs_dx) && (major_len >= abs_dy))
    else $error("major length below an axis delta");

  a_sign_zero: assert property (@(posedge clk) disable iff (rst)
    (abs_dx == '0) == (step_sign_x == SIGN_ZERO))
    else $error("x step sign disagrees with x delta");

  a_last_idles: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.pixel.last_pixel |=> !line_active)
    else $error("line still active after its last pixel");
`endif

endmodule

`default_nettype wire

FILE: sv/line_pixel_stepper.sv
// ----------------------------------------------------------------------------
// line_pixel_stepper
// Line rasterizer: a start item loads a line and yields its first pixel,
// each step item yields the next pixel until the last one is flagged.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload     handshake
//   step     in         lps_in_t    step_valid / step_ready
//   pixel    out        lps_out_t   pixel_valid / pixel_ready
//
// one item per clock sustained while pixel_ready stays high; an accepted item
// waits in the input register, then the stepping logic loads its pixel into
// the pixel register once that register is free
// the stepping logic is a single pass: one add, one compare and one subtract
// per axis, so back to back steps along the same line never wait
// reset clears the line state (idle) and both valid flags
// a stalled pixel register holds its item; step_ready then drops only once
// the input register is also full
// a step item while idle, or after the last pixel, is taken and gives no pixel
//
`default_nettype none

module line_pixel_stepper
  import lps_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step_valid,
  output logic          step_ready,
  input  wire lps_in_t  step_data,
  output logic          pixel_valid,
  input  wire logic     pixel_ready,
  output lps_out_t      pixel_data
);

  logic     held_valid;
  lps_in_t  held_item;
  logic     advance;
  lps_res_t result;

  // the held item moves on whenever the pixel register can take a result
  assign advance = held_valid && (!pixel_valid || pixel_ready);

  lps_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .step_valid (step_valid),
    .step_ready (step_ready),
    .step_data  (step_data),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  lps_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (held_item),
    .result (result)
  );

  // pixel register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (result.valid) begin
      pixel_valid <= 1'b1;
    end else if (pixel_ready) begin
      pixel_valid <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (result.valid) begin
      pixel_data <= result.pixel;
    end
  end

`ifndef SYNTHESIS
  // a result is only produced when the pixel register is free to take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (!pixel_valid || pixel_ready))
    else $error("pixel register overwritten while stalled");

  // a held item waiting on a free pixel register is processed in the same cycle
  a_drain: assert property (@(posedge clk) disable iff (rst)
    held_valid && !pixel_valid |-> advance)
    else $error("held item not processed with pixel register free");

  // with both stages stalled, nothing new is taken
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    held_valid && pixel_valid && !pixel_ready |-> !step_ready)
    else $error("item taken while both stages are full");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_line_pixel_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_pixel_stepper
// Self-checking bench for the line rasterizer. A local line tracer predicts
// every pixel from the accepted start and step items. A checker compares
// each pixel the block hands out, field by field, with the oldest pending
// prediction. Directed lines cover the corners of the coordinate range,
// single-pixel lines, several directions and an abandoned line. A back-pressure
// phase follows, then random lines with idle bursts on both channels, and a
// final stretch at full rate.
// ----------------------------------------------------------------------------

module tb_line_pixel_stepper;
  import lps_pkg::*;

  localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
  // no handshake on either channel for this many cycles means the block hung;
  // the longest honest quiet stretch is the back-pressure hold below
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 48;
  // pixel register plus input register, with margin
  localparam int TAIL_CYCLES    = 16;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     step_valid = 1'b0;
  logic     step_ready;
  lps_in_t  step_data = '0;
  logic     pixel_valid;
  logic     pixel_ready = 1'b0;
  lps_out_t pixel_data;

  line_pixel_stepper dut (
    .clk         (clk),
    .rst         (rst),
    .step_valid  (step_valid),
    .step_ready  (step_ready),
    .step_data   (step_data),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_data  (pixel_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // line tracer: our own copy of the line state
  // --------------------------------------------------------------------------
  coord_t trace_x, trace_y;
  err_t   trace_err_x, trace_err_y;
  coord_t trace_dx, trace_dy;
  coord_t trace_major;
  sign_t  trace_sx, trace_sy;
  count_t trace_count;
  color_t trace_color;
  logic   trace_active = 1'b0;

  lps_out_t expected_pixels[$];
  int       pixels_due = 0;
  int       mismatches = 0;

  // idle controls shared between the stimulus and the pixel sink
  bit src_gaps    = 1'b0;
  bit sink_stalls = 1'b0;
  int hold_req    = 0;

  function automatic coord_t step_axis(input coord_t pos, input sign_t sgn);
    if (sgn == SIGN_POS) return pos + coord_t'(1);
    if (sgn == SIGN_NEG) return pos - coord_t'(1);
    return pos;
  endfunction

  // advances the traced line by one accepted item; returns 1 when that
  // item gives a pixel, with the pixel in px
  function automatic bit trace_line(input lps_in_t it, output lps_out_t px);
    px = '0;
    if (it.cmd == CMD_START) begin
      if (it.end_x > it.start_x) begin
        trace_dx = it.end_x - it.start_x;
        trace_sx = SIGN_POS;
      end else if (it.end_x == it.start_x) begin
        trace_dx = '0;
        trace_sx = SIGN_ZERO;
      end else begin
        trace_dx = it.start_x - it.end_x;
        trace_sx = SIGN_NEG;
      end
      if (it.end_y > it.start_y) begin
        trace_dy = it.end_y - it.start_y;
        trace_sy = SIGN_POS;
      end else if (it.end_y == it.start_y) begin
        trace_dy = '0;
        trace_sy = SIGN_ZERO;
      end else begin
        trace_dy = it.start_y - it.end_y;
        trace_sy = SIGN_NEG;
      end
      // ties go to the y delta, same value either way
      trace_major  = (trace_dx > trace_dy) ? trace_dx : trace_dy;
      trace_x      = it.start_x;
      trace_y      = it.start_y;
      trace_err_x  = '0;
      trace_err_y  = '0;
      trace_count  = '0;
      trace_color  = it.pen_color;
      trace_active = 1'b1;
    end else if (!trace_active) begin
      // step with no line in progress is swallowed
      return 1'b0;
    end

    px.pixel_x     = trace_x;
    px.pixel_y     = trace_y;
    px.pixel_color = trace_color;
    px.last_pixel  = (trace_count == count_t'(trace_major));

    if (px.last_pixel) begin
      trace_active = 1'b0;
    end else begin
      trace_count = trace_count + count_t'(1);
      // errors stay within 0..2*major, which fits the 11-bit accumulator
      trace_err_x = trace_err_x + err_t'(trace_dx);
      trace_err_y = trace_err_y + err_t'(trace_dy);
      if (trace_err_x > err_t'(trace_major)) begin
        trace_err_x = trace_err_x - err_t'(trace_major);
        trace_x     = step_axis(trace_x, trace_sx);
      end
      if (trace_err_y > err_t'(trace_major)) begin
        trace_err_y = trace_err_y - err_t'(trace_major);
        trace_y     = step_axis(trace_y, trace_sy);
      end
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // handshake signals are read right after the edge, so these are the values
  // the block saw at that edge
  always @(posedge clk) begin : pixel_check
    lps_out_t want;
    if (!rst && pixel_valid && pixel_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel (%0d,%0d) with nothing pending",
                                  pixel_data.pixel_x, pixel_data.pixel_y));
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_data.pixel_x !== want.pixel_x)
          report_mismatch($sformatf("pixel_x got %0d want %0d",
                                    pixel_data.pixel_x, want.pixel_x));
        if (pixel_data.pixel_y !== want.pixel_y)
          report_mismatch($sformatf("pixel_y got %0d want %0d",
                                    pixel_data.pixel_y, want.pixel_y));
        if (pixel_data.pixel_color !== want.pixel_color)
          report_mismatch($sformatf("pixel_color got %h want %h",
                                    pixel_data.pixel_color, want.pixel_color));
        if (pixel_data.last_pixel !== want.last_pixel)
          report_mismatch($sformatf("last_pixel got %b want %b at (%0d,%0d)",
                                    pixel_data.last_pixel, want.last_pixel,
                                    want.pixel_x, want.pixel_y));
      end
    end
  end

  // watchdog: counts cycles with no handshake on either channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((step_valid && step_ready) || (pixel_valid && pixel_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_line_pixel_stepper: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // pixel sink: one assignment to pixel_ready per edge at most
  // --------------------------------------------------------------------------
  initial begin : pixel_sink
    int n;
    @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        // long hold-off so the block fills and stops taking items
        n = hold_req;
        hold_req = 0;
        pixel_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        pixel_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        pixel_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // item sender
  // --------------------------------------------------------------------------
  // step_valid stays high after an accepted item, so back to back items never
  // lower and raise it at the same edge; it only drops ahead of a gap or a drain
  task automatic send_item(input lps_in_t it);
    lps_out_t px;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      step_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    step_valid <= 1'b1;
    step_data  <= it;
    do @(posedge clk); while (!step_ready);
    if (trace_line(it, px)) begin
      expected_pixels.push_back(px);
      pixels_due++;
    end
  endtask

  function automatic lps_in_t start_item(input int x0, input int y0,
                                         input int x1, input int y1,
                                         input int color);
    lps_in_t it;
    it.cmd       = CMD_START;
    it.start_x   = coord_t'(x0);
    it.start_y   = coord_t'(y0);
    it.end_x     = coord_t'(x1);
    it.end_y     = coord_t'(y1);
    it.pen_color = color_t'(color);
    return it;
  endfunction

  // random fields everywhere; a step ignores them but they still toggle
  function automatic lps_in_t random_item(input logic cmd);
    lps_in_t it;
    it.cmd       = cmd;
    it.start_x   = coord_t'($urandom);
    it.start_y   = coord_t'($urandom);
    it.end_x     = coord_t'($urandom);
    it.end_y     = coord_t'($urandom);
    it.pen_color = color_t'($urandom);
    return it;
  endfunction

  task automatic send_steps(input int n);
    repeat (n) send_item(random_item(CMD_STEP));
  endtask

  // endpoint a few pixels away, kept inside the coordinate range
  function automatic coord_t near_coord(input coord_t c);
    int d;
    d = $urandom_range(0, 9);
    if ($urandom_range(0, 1) == 1)
      return (int'(c) + d <= COORD_MAX) ? coord_t'(int'(c) + d) : coord_t'(int'(c) - d);
    return (int'(c) >= d) ? coord_t'(int'(c) - d) : coord_t'(int'(c) + d);
  endfunction

  // drop valid, then wait for every predicted pixel to arrive
  task automatic wait_drained();
    step_valid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // step straight out of reset: nothing to draw
  task automatic test_idle_step();
    send_steps(1);
    wait_drained();
  endtask

  // equal endpoints at both corners; the step after the only pixel is idle
  task automatic test_single_pixel();
    send_item(start_item(0, 0, 0, 0, 16'h0000));
    send_steps(1);
    send_item(start_item(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 16'hFFFF));
    wait_drained();
  endtask

  // horizontal leftward from the right edge, steep up-left from the bottom
  // edge, shallow down-right; one extra step past the end of the first
  task automatic test_axis_lines();
    send_item(start_item(COORD_MAX, 0, COORD_MAX - 3, 0, 16'hF800));
    send_steps(4);
    send_item(start_item(2, COORD_MAX, 0, COORD_MAX - 3, 16'h07E0));
    send_steps(3);
    send_item(start_item(100, 50, 104, 52, 16'h001F));
    send_steps(4);
    wait_drained();
  endtask

  // full diagonal across the range, left after two steps for a new line
  task automatic test_abandoned_line();
    send_item(start_item(0, 0, COORD_MAX, COORD_MAX, 16'hA5A5));
    send_steps(2);
    send_item(start_item(COORD_MAX, 0, 0, COORD_MAX, 16'h5A5A));
    send_steps(1);
    wait_drained();
  endtask

  // sink holds off while the sender keeps offering steps of a long line
  task automatic test_backpressure();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    hold_req    = HOLD_CYCLES;
    send_item(start_item(10, 500, 40, 480, 16'h1234));
    send_steps(30);
    wait_drained();
  endtask

  // mostly complete short lines, some cut short, some long lines abandoned,
  // and stray steps
  task automatic test_random_lines(input int pixel_goal);
    lps_in_t it;
    int      kind;
    int      stop;
    stop = pixels_due + pixel_goal;
    while (pixels_due < stop) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        it = random_item(CMD_START);
        it.end_x = near_coord(it.start_x);
        it.end_y = near_coord(it.start_y);
        send_item(it);
        if (kind == 6)
          send_steps($urandom_range(0, int'(trace_major)));
        else
          send_steps(int'(trace_major) + $urandom_range(0, 2));
      end else if (kind <= 8) begin
        send_item(random_item(CMD_START));
        send_steps($urandom_range(0, 12));
      end else begin
        send_steps($urandom_range(1, 3));
      end
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    test_idle_step();
    test_single_pixel();
    test_axis_lines();
    test_abandoned_line();
    test_backpressure();

    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    test_random_lines(320);

    // full rate to the end
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    test_random_lines(40);

    // let any stray pixel show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb_line_pixel_stepper: clean");
    else
      $display("tb_line_pixel_stepper: errors");
    $finish;
  end

endmodule

FILE: line_pixel_stepper.f
sv/lps_pkg.sv
sv/lps_in_reg.sv
sv/lps_core.sv
sv/line_pixel_stepper.sv
dv/tb_line_pixel_stepper.sv
